/* sv/crcbu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC byte register update package
// Shared types, register codes and reset constants for the CRC block.
// ----------------------------------------------------------------------------
package crcbu_pkg;

    // Default register width in bytes.
    localparam int unsigned CRC_BYTES_DEF = 4;

    // Reset values of the configuration registers.
    localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [31:0] INIT_RESET = 32'hFFFF_FFFF;
    localparam logic        LSB_RESET  = 1'b0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_POLY = 2'd0,
        CFG_INIT = 2'd1,
        CFG_LSB  = 2'd2
    } t_cfg_idx;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] poly;
        logic [31:0] init;
        logic        lsb_first;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       half_byte;
    } t_item;

endpackage

/* sv/crcbu_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC configuration registers
// Holds polynomial, initial value and bit order, written through the
// configuration channel.
// ----------------------------------------------------------------------------
module crcbu_cfg
    import crcbu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    logic [31:0] r_poly;
    logic [31:0] r_init;
    logic        r_lsb_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLY_RESET;
            r_init      <= INIT_RESET;
            r_lsb_first <= LSB_RESET;
        end else if (i_wr) begin
            // Indexes beyond the register list are dropped.
            unique case (t_cfg_idx'(i_index))
                CFG_POLY: r_poly      <= i_data;
                CFG_INIT: r_init      <= i_data;
                CFG_LSB:  r_lsb_first <= i_data[0];
                default:  ;
            endcase
        end
    end

    assign o_cfg.poly      = r_poly;
    assign o_cfg.init      = r_init;
    assign o_cfg.lsb_first = r_lsb_first;

endmodule

/* sv/crcbu_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC register engine
// Folds one byte or nibble into the CRC register per cycle while the result
// register has room, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module crcbu_engine
    import crcbu_pkg::*;
#(
    parameter int unsigned CRC_BYTES = CRC_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic        i_out_ready,
    output logic        o_room,
    output logic        o_out_valid,
    output logic [31:0] o_crc
);

    localparam int unsigned W = 8 * CRC_BYTES;

    logic [W-1:0]   r_crc;
    logic [31:0]    r_out;
    logic           r_out_valid;

    logic [W+31:0]  poly_ext;
    logic [W+31:0]  init_ext;
    logic [W-1:0]   poly_w;
    logic [W-1:0]   init_w;
    logic [7:0]     d_msb;
    logic [7:0]     d_lsb;
    logic [W+7:0]   msb_wide;
    logic [W+7:0]   lsb_wide;
    logic [W-1:0]   base;
    logic [W-1:0]   s [0:8];
    logic [W-1:0]   n_crc;
    logic [W+31:0]  out_ext;
    logic [W+31:0]  rst_ext;

    // Fit the 32-bit registers to the CRC width.
    assign poly_ext = {{W{1'b0}}, i_cfg.poly};
    assign init_ext = {{W{1'b0}}, i_cfg.init};
    assign poly_w   = poly_ext[W-1:0];
    assign init_w   = init_ext[W-1:0];
    assign rst_ext  = {{W{1'b0}}, INIT_RESET};

    // Only the nibble that is processed gets folded in.
    assign d_msb    = i_item.half_byte ? {i_item.data_byte[7:4], 4'h0} : i_item.data_byte;
    assign d_lsb    = i_item.half_byte ? {4'h0, i_item.data_byte[3:0]} : i_item.data_byte;
    assign msb_wide = {d_msb, {W{1'b0}}};
    assign lsb_wide = {{W{1'b0}}, d_lsb};

    always_comb begin
        base = i_item.restart ? init_w : r_crc;
        if (i_cfg.lsb_first) begin
            s[0] = base ^ lsb_wide[W-1:0];
        end else begin
            s[0] = base ^ msb_wide[W+7:8];
        end
        for (int i = 0; i < 8; i++) begin
            if (i_cfg.lsb_first) begin
                s[i+1] = (s[i] >> 1) ^ (s[i][0] ? poly_w : '0);
            end else begin
                s[i+1] = (s[i] << 1) ^ (s[i][W-1] ? poly_w : '0);
            end
        end
        n_crc = i_item.half_byte ? s[4] : s[8];
    end

    assign out_ext = {{32{1'b0}}, n_crc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= rst_ext[W-1:0];
            r_out_valid <= 1'b0;
        end else begin
            if (i_fire) begin
                r_crc       <= n_crc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_out <= out_ext[31:0];
        end
    end

    assign o_room      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_crc       = r_out;

endmodule

/* sv/crc_byte_register_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC byte register update
// Generic CRC register with configurable polynomial, initial value and bit
// order, folding one message byte (or nibble) per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the slave stream: tdata carries the message byte, tuser
//   carries the restart flag (bit 0) and the nibble-mode flag (bit 1). Each
//   accepted transaction yields exactly one transaction on the master stream
//   whose tdata is the CRC register after that byte.
//   An accepted byte sits in the input register until the result register
//   has room, and the result register is then loaded from it; the master
//   side sees the result once the result register holds it. Throughput is
//   one byte per cycle while the receiver keeps taking results; the eight
//   shift/XOR steps of one byte are unrolled between the input register
//   and the result register.
//   When the receiver stalls, the result register holds its transaction and
//   the input register takes one more byte; after that tready drops until the
//   receiver takes the waiting result.
//   Reset loads the polynomial 0x04C11DB7, initial value 0xFFFFFFFF and
//   msb-first order, and presets the CRC register to the initial value.
//   Configuration writes go through a separate valid/ready channel that is
//   always ready; they are meant to be issued while no byte is in flight.
// ----------------------------------------------------------------------------
module crc_byte_register_update
    import crcbu_pkg::*;
#(
    parameter int unsigned CRC_BYTES = CRC_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [0] restart, [1] half_byte
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] crc_value
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg   cfg;
    t_item  r_item;
    logic   r_in_valid;
    logic   room;
    logic   fire;
    logic   s_accept;

    // The configuration registers are always writable.
    assign o_cfg_ready = 1'b1;

    crcbu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The held byte moves on whenever the result register has room, which
    // includes the cycle in which the receiver takes the previous result.
    assign fire            = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || room;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item.data_byte <= i_s_axis_tdata;
            r_item.restart   <= i_s_axis_tuser[0];
            r_item.half_byte <= i_s_axis_tuser[1];
        end
    end

    crcbu_engine #(
        .CRC_BYTES (CRC_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_out_ready (i_m_axis_tready),
        .o_room      (room),
        .o_out_valid (o_m_axis_tvalid),
        .o_crc       (o_m_axis_tdata)
    );

`ifndef SYNTH
    // A byte waiting with an empty result register is delivered next cycle.
    a_pending_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("held byte did not reach the result register");

    // A held byte is not dropped while the result side stalls.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_m_axis_tvalid && !i_m_axis_tready |=> r_in_valid)
        else $error("held byte lost during output stall");

    // The input side only stalls when both stages are occupied and blocked.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a blocked result");
`endif

endmodule
